// ----- hw/rtl/mpt_pkg.sv -----
// shared types, codes and constants for the mouse packet tracker
`default_nettype none

package mpt_pkg;

    // request codes carried in the operation field
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_POLL  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_e_t;

    // position of the decoder inside a three-byte packet
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    // answer kinds
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // field widths
    localparam int unsigned POS_W    = 15;
    localparam int unsigned MOTION_W = 16;
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 1'd1;

    // header byte pattern 10000xxx
    localparam logic [7:0] HDR_MASK = 8'hF8;
    localparam logic [7:0] HDR_CODE = 8'h80;

    // acceleration: slow and fast scale shifts, threshold on |dx|+|dy|
    localparam int unsigned SHIFT_SLOW   = 5;
    localparam int unsigned SHIFT_FAST   = 6;
    localparam logic [17:0] ACCEL_THRESH = 18'd4;

    localparam logic [POS_W-1:0] LIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        op_e_t              operation;
        logic [7:0]         device_byte;
        logic [BTN_W-1:0]   button_mask;
        logic [POS_W-1:0]   new_x;
        logic [POS_W-1:0]   new_y;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [BTN_W-1:0]   buttons_down;
        logic [BTN_W-1:0]   buttons_hit;
        logic               polled_hit;
        logic               answer_kind;
    } rsp_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mpt_ifs.sv -----
// valid/ready channel interfaces for requests and answers
`default_nettype none

interface mpt_req_if;
    import mpt_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mpt_rsp_if;
    import mpt_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mpt_axis.sv -----
// one axis of a position read: scale motion, add to position, clamp to 0..limit
`default_nettype none

module mpt_axis (
    input  wire logic [mpt_pkg::POS_W-1:0]           pos,
    input  wire logic signed [mpt_pkg::MOTION_W-1:0] motion,
    input  wire logic                                fast,
    input  wire logic [mpt_pkg::POS_W-1:0]           limit,
    output logic      [mpt_pkg::POS_W-1:0]           pos_next
);
    import mpt_pkg::*;

    localparam int unsigned SUM_W = MOTION_W + SHIFT_FAST + 2;

    logic signed [SUM_W-1:0] motion_ext;
    logic signed [SUM_W-1:0] scaled;
    logic signed [SUM_W-1:0] sum;

    // scale by 32 or 64 and add the current position
    always_comb
    begin
        motion_ext = SUM_W'(motion);
        scaled     = fast ? (motion_ext <<< SHIFT_FAST) : (motion_ext <<< SHIFT_SLOW);
        sum        = scaled + $signed({{(SUM_W-POS_W){1'b0}}, pos});
    end

    // clamp into 0..limit
    always_comb
    begin
        if (sum < 0)
        begin
            pos_next = '0;
        end
        else if (sum > $signed({{(SUM_W-POS_W){1'b0}}, limit}))
        begin
            pos_next = limit;
        end
        else
        begin
            pos_next = sum[POS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mouse_packet_tracker_unit.sv -----
// top level of the mouse packet tracker: byte decoder, motion accumulators, host requests
`default_nettype none

// Decodes a three-byte mouse stream (header 10000xxx with inverted button bits, then
// signed dx and dy) and answers host requests. Every request beat passes through a
// registered input stage and one pass of logic into the answer register, so a new beat
// is accepted every cycle unless an answer waits in the answer register and the answer
// side is not ready; only a button poll or a position read produces an answer beat,
// which is registered at the edge where the request leaves the input stage. Device bytes
// and position writes produce no answer. The answer register holds a waiting answer
// while the input stage keeps taking beats that produce none. The limit registers
// are written through cfg_we, cfg_index and cfg_data and act at the next position read.
module mouse_packet_tracker_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mpt_req_if.sink                              req,
    mpt_rsp_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mpt_pkg::POS_W-1:0]       cfg_data
);
    import mpt_pkg::*;

    // input stage
    logic      req_valid_reg;
    req_item_t req_reg;

    // answer stage
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;

    // configuration
    logic [POS_W-1:0] x_limit_reg;
    logic [POS_W-1:0] y_limit_reg;

    // tracker state
    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [BTN_W-1:0]            buttons_last_reg;
    logic [BTN_W-1:0]            buttons_last_next;
    logic [BTN_W-1:0]            hit_bits_reg;
    logic [BTN_W-1:0]            hit_bits_next;
    logic signed [MOTION_W-1:0]  motion_x_reg;
    logic signed [MOTION_W-1:0]  motion_x_next;
    logic signed [MOTION_W-1:0]  motion_y_reg;
    logic signed [MOTION_W-1:0]  motion_y_next;
    logic [POS_W-1:0]            position_x_reg;
    logic [POS_W-1:0]            position_x_next;
    logic [POS_W-1:0]            position_y_reg;
    logic [POS_W-1:0]            position_y_next;

    logic                        has_answer;
    logic                        fire;
    logic                        is_header;
    logic [BTN_W-1:0]            hdr_down;
    logic signed [MOTION_W:0]    sat_sum;
    logic signed [MOTION_W-1:0]  sat_acc;
    logic signed [MOTION_W-1:0]  sat_res;
    logic [MOTION_W:0]           abs_x;
    logic [MOTION_W:0]           abs_y;
    logic [MOTION_W+1:0]         abs_sum;
    logic                        fast;
    logic [POS_W-1:0]            read_x;
    logic [POS_W-1:0]            read_y;

    // handshake: the input stage moves on unless an answer has nowhere to go
    assign has_answer = (req_reg.operation == OP_POLL) || (req_reg.operation == OP_READ);
    assign fire       = req_valid_reg && (!has_answer || !rsp_valid_reg || rsp.ready);
    assign req.ready  = !req_valid_reg || fire;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= LIMIT_RESET;
            y_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // header detection
    assign is_header = (req_reg.device_byte & HDR_MASK) == HDR_CODE;
    assign hdr_down  = ~req_reg.device_byte[BTN_W-1:0];

    // saturating add of the signed byte into the accumulator picked by the phase
    always_comb
    begin
        sat_acc = (phase_reg == PH_DX) ? motion_x_reg : motion_y_reg;
        sat_sum = {sat_acc[MOTION_W-1], sat_acc}
                + {{(MOTION_W-7){req_reg.device_byte[7]}}, req_reg.device_byte};
        if (sat_sum[MOTION_W] != sat_sum[MOTION_W-1])
        begin
            sat_res = sat_sum[MOTION_W] ? {1'b1, {(MOTION_W-1){1'b0}}}
                                        : {1'b0, {(MOTION_W-1){1'b1}}};
        end
        else
        begin
            sat_res = sat_sum[MOTION_W-1:0];
        end
    end

    // acceleration select from |motion_x| + |motion_y|
    always_comb
    begin
        abs_x   = motion_x_reg[MOTION_W-1] ? -{motion_x_reg[MOTION_W-1], motion_x_reg}
                                           : {motion_x_reg[MOTION_W-1], motion_x_reg};
        abs_y   = motion_y_reg[MOTION_W-1] ? -{motion_y_reg[MOTION_W-1], motion_y_reg}
                                           : {motion_y_reg[MOTION_W-1], motion_y_reg};
        abs_sum = {1'b0, abs_x} + {1'b0, abs_y};
        fast    = abs_sum >= ACCEL_THRESH;
    end

    mpt_axis u_axis_x (
        .pos      (position_x_reg),
        .motion   (motion_x_reg),
        .fast     (fast),
        .limit    (x_limit_reg),
        .pos_next (read_x)
    );

    mpt_axis u_axis_y (
        .pos      (position_y_reg),
        .motion   (motion_y_reg),
        .fast     (fast),
        .limit    (y_limit_reg),
        .pos_next (read_y)
    );

    // packet phase state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // next state of the packet decoder and the rest of the tracker
    always_comb
    begin
        phase_next        = phase_reg;
        buttons_last_next = buttons_last_reg;
        hit_bits_next     = hit_bits_reg;
        motion_x_next     = motion_x_reg;
        motion_y_next     = motion_y_reg;
        position_x_next   = position_x_reg;
        position_y_next   = position_y_reg;
        rsp_next          = '0;
        rsp_next.buttons_down = buttons_last_reg;
        rsp_next.buttons_hit  = hit_bits_reg;
        if (fire)
        begin
            case (req_reg.operation)
                OP_BYTE:
                begin
                    case (phase_reg)
                        PH_DX:
                        begin
                            motion_x_next = sat_res;
                            phase_next    = PH_DY;
                        end
                        PH_DY:
                        begin
                            motion_y_next = sat_res;
                            phase_next    = PH_HEADER;
                        end
                        default:
                        begin
                            if (is_header)
                            begin
                                hit_bits_next     = hit_bits_reg | (hdr_down & ~buttons_last_reg);
                                buttons_last_next = hdr_down;
                                phase_next        = PH_DX;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    endcase
                end
                OP_POLL:
                begin
                    hit_bits_next        = hit_bits_reg & ~req_reg.button_mask;
                    rsp_next.polled_hit  = |(hit_bits_reg & req_reg.button_mask);
                    rsp_next.answer_kind = KIND_POLL;
                end
                OP_READ:
                begin
                    position_x_next      = read_x;
                    position_y_next      = read_y;
                    motion_x_next        = '0;
                    motion_y_next        = '0;
                    rsp_next.pos_x       = read_x;
                    rsp_next.pos_y       = read_y;
                    rsp_next.answer_kind = KIND_READ;
                end
                default:
                begin
                    position_x_next = req_reg.new_x;
                    position_y_next = req_reg.new_y;
                end
            endcase
        end
    end

    // tracker state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_last_reg <= '0;
            hit_bits_reg     <= '0;
            motion_x_reg     <= '0;
            motion_y_reg     <= '0;
            position_x_reg   <= '0;
            position_y_reg   <= '0;
        end
        else
        begin
            buttons_last_reg <= buttons_last_next;
            hit_bits_reg     <= hit_bits_next;
            motion_x_reg     <= motion_x_next;
            motion_y_reg     <= motion_y_next;
            position_x_reg   <= position_x_next;
            position_y_reg   <= position_y_next;
        end
    end

    // answer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire && has_answer)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_answer)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef ASSERT_OFF
    // a position read empties both accumulators
    a_read_clears_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg.operation == OP_READ) |=> (motion_x_reg == '0 && motion_y_reg == '0))
        else $error("motion not cleared by position read");

    // a read answer never exceeds the limits in force
    a_read_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg.operation == OP_READ) |=>
            (rsp_valid_reg && rsp_reg.pos_x <= $past(x_limit_reg)
             && rsp_reg.pos_y <= $past(y_limit_reg)))
        else $error("read answer outside limits");

    // a poll clears every asked hit bit
    a_poll_clears_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg.operation == OP_POLL) |=>
            ((hit_bits_reg & $past(req_reg.button_mask)) == '0))
        else $error("asked hit bits survive a poll");

    // a held input beat is never dropped
    a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !fire) |=> req_valid_reg)
        else $error("stalled request lost");
`endif

endmodule

`default_nettype wire

// ----- sim/mouse_packet_tracker_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for the mouse packet tracker: directed and random requests checked against a predictor
module mouse_packet_tracker_unit_tb;
    import mpt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;

    mpt_req_if req_ch ();
    mpt_rsp_if rsp_ch ();

    mouse_packet_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted tracker state
    phase_t                      pkt_phase;
    logic [BTN_W-1:0]            held_buttons;
    logic [BTN_W-1:0]            sticky_hits;
    logic signed [MOTION_W-1:0]  motion_x_acc;
    logic signed [MOTION_W-1:0]  motion_y_acc;
    logic [POS_W-1:0]            cur_x;
    logic [POS_W-1:0]            cur_y;
    logic [POS_W-1:0]            limit_x;
    logic [POS_W-1:0]            limit_y;

    rsp_item_t pending_answers[$];
    int        error_count   = 0;
    int        cycle_count   = 0;
    int        answer_holdoff = 0;
    int        requests_sent = 0;
    bit        no_idle       = 1'b0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // add a signed motion byte to a 16-bit accumulator with saturation
    function automatic logic signed [MOTION_W-1:0] saturate_motion(
        input logic signed [MOTION_W-1:0] acc, input logic [7:0] delta);
        int s;
        s = int'(acc) + int'($signed(delta));
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return MOTION_W'(s);
    endfunction

    // move one coordinate by scaled motion and clamp to 0..limit
    function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
        input logic signed [MOTION_W-1:0] motion, input int unsigned shift,
        input logic [POS_W-1:0] limit);
        longint v;
        v = longint'(pos) + longint'(motion) * (longint'(1) << shift);
        if (v < 0)
            v = 0;
        if (v > longint'(limit))
            v = longint'(limit);
        return POS_W'(v);
    endfunction

    // update the predicted state for one accepted beat, queue any answer
    function automatic void track_request(input req_item_t r);
        rsp_item_t    ans;
        int           abs_x;
        int           abs_y;
        int unsigned  shift;
        logic [BTN_W-1:0] down;
        case (r.operation)
            OP_BYTE:
            begin
                case (pkt_phase)
                    PH_DX:
                    begin
                        motion_x_acc = saturate_motion(motion_x_acc, r.device_byte);
                        pkt_phase = PH_DY;
                    end
                    PH_DY:
                    begin
                        motion_y_acc = saturate_motion(motion_y_acc, r.device_byte);
                        pkt_phase = PH_HEADER;
                    end
                    default:
                    begin
                        if ((r.device_byte & HDR_MASK) == HDR_CODE)
                        begin
                            down = ~r.device_byte[BTN_W-1:0];
                            sticky_hits = sticky_hits | (down & ~held_buttons);
                            held_buttons = down;
                            pkt_phase = PH_DX;
                        end
                        else
                            pkt_phase = PH_HEADER;
                    end
                endcase
            end
            OP_WRITE:
            begin
                cur_x = r.new_x;
                cur_y = r.new_y;
            end
            default:
            begin
                ans = '0;
                ans.buttons_down = held_buttons;
                ans.buttons_hit = sticky_hits;
                if (r.operation == OP_POLL)
                begin
                    ans.polled_hit = |(sticky_hits & r.button_mask);
                    sticky_hits = sticky_hits & ~r.button_mask;
                    ans.answer_kind = KIND_POLL;
                end
                else
                begin
                    abs_x = (motion_x_acc < 0) ? -int'(motion_x_acc) : int'(motion_x_acc);
                    abs_y = (motion_y_acc < 0) ? -int'(motion_y_acc) : int'(motion_y_acc);
                    shift = (abs_x + abs_y < 4) ? SHIFT_SLOW : SHIFT_FAST;
                    cur_x = clamp_axis(cur_x, motion_x_acc, shift, limit_x);
                    cur_y = clamp_axis(cur_y, motion_y_acc, shift, limit_y);
                    motion_x_acc = '0;
                    motion_y_acc = '0;
                    ans.pos_x = cur_x;
                    ans.pos_y = cur_y;
                    ans.answer_kind = KIND_READ;
                end
                pending_answers.push_back(ans);
            end
        endcase
    endfunction

    // compare one answer beat with the oldest expectation
    task automatic check_answer(input rsp_item_t got);
        rsp_item_t exp_ans;
        if (pending_answers.size() == 0)
        begin
            error_count++;
            $error("answer beat with nothing expected: %h", got);
            return;
        end
        exp_ans = pending_answers.pop_front();
        if (got.pos_x !== exp_ans.pos_x)
        begin
            error_count++;
            $error("pos_x expected %0d got %0d", exp_ans.pos_x, got.pos_x);
        end
        if (got.pos_y !== exp_ans.pos_y)
        begin
            error_count++;
            $error("pos_y expected %0d got %0d", exp_ans.pos_y, got.pos_y);
        end
        if (got.buttons_down !== exp_ans.buttons_down)
        begin
            error_count++;
            $error("buttons_down expected %0d got %0d", exp_ans.buttons_down, got.buttons_down);
        end
        if (got.buttons_hit !== exp_ans.buttons_hit)
        begin
            error_count++;
            $error("buttons_hit expected %0d got %0d", exp_ans.buttons_hit, got.buttons_hit);
        end
        if (got.polled_hit !== exp_ans.polled_hit)
        begin
            error_count++;
            $error("polled_hit expected %0d got %0d", exp_ans.polled_hit, got.polled_hit);
        end
        if (got.answer_kind !== exp_ans.answer_kind)
        begin
            error_count++;
            $error("answer_kind expected %0d got %0d", exp_ans.answer_kind, got.answer_kind);
        end
    endtask

    // answer side: check beats, random stalls and long hold-offs
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_answer(rsp_ch.data);
            if (rst_n !== 1'b1)
                rsp_ch.ready <= 1'b0;
            else if (answer_holdoff > 0)
            begin
                answer_holdoff--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // offer one request beat, with random idle cycles ahead of it
    task automatic send_request(input req_item_t item);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= item;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        track_request(item);
        requests_sent++;
    endtask

    // request with every field random apart from the operation
    function automatic req_item_t random_fill(input op_e_t op);
        req_item_t r;
        r.operation = op;
        r.device_byte = 8'($urandom);
        r.button_mask = BTN_W'($urandom);
        r.new_x = POS_W'($urandom);
        r.new_y = POS_W'($urandom);
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        req_item_t r;
        r = random_fill(OP_BYTE);
        r.device_byte = b;
        send_request(r);
    endtask

    task automatic send_poll(input logic [BTN_W-1:0] mask);
        req_item_t r;
        r = random_fill(OP_POLL);
        r.button_mask = mask;
        send_request(r);
    endtask

    task automatic send_read();
        send_request(random_fill(OP_READ));
    endtask

    task automatic send_write(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        req_item_t r;
        r = random_fill(OP_WRITE);
        r.new_x = x;
        r.new_y = y;
        send_request(r);
    endtask

    // stop offering beats and let every expected answer and pipeline stage drain
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // limit register write, only while the block is idle
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_X_LIMIT)
            limit_x = value;
        else
            limit_y = value;
        @(posedge clk);
    endtask

    function automatic logic [7:0] random_header();
        return HDR_CODE | 8'($urandom_range(7));
    endfunction

    // partly small motion (-2..2) so both scale factors come up
    function automatic logic [7:0] random_motion_byte();
        if ($urandom_range(9) < 4)
            return 8'(int'($urandom_range(4)) - 2);
        return 8'($urandom);
    endfunction

    // a packet, sometimes interrupted by a host request or cut short
    task automatic send_packet();
        send_byte(random_header());
        if ($urandom_range(9) == 0)
            send_request(random_fill(op_e_t'($urandom_range(1, 3))));
        send_byte(random_motion_byte());
        if ($urandom_range(9) == 0)
            send_request(random_fill(op_e_t'($urandom_range(1, 3))));
        if ($urandom_range(19) != 0)
            send_byte(random_motion_byte());
    endtask

    // answers straight after reset
    task automatic test_reset_answers();
        send_poll(3'b111);
        send_read();
    endtask

    // headers, motion, stray bytes, polls, reads and the acceleration threshold
    task automatic test_packet_decoding();
        // stray bytes outside a packet
        send_byte(8'h00);
        send_byte(8'hFF);
        // header with no buttons, extreme motion
        send_byte(8'h87);
        send_byte(8'h7F);
        send_byte(8'h80);
        // all buttons down, header-looking motion bytes
        send_byte(8'h80);
        send_byte(8'h81);
        send_byte(8'h82);
        send_poll(3'b000);
        send_poll(3'b101);
        send_poll(3'b111);
        send_read();
        // partial packet: dx only, then a read
        send_write(15'h7FFF, 15'h7FFF);
        send_byte(8'h86);
        send_byte(8'h01);
        send_read();
        // the pending dy, then motion summing to exactly four
        send_byte(8'h03);
        send_byte(8'h84);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_read();
        send_poll(3'b111);
    endtask

    // limits at zero, a small value and full range; writes are not clamped, reads are
    task automatic test_limits();
        wait_idle();
        write_limit(REG_X_LIMIT, 15'd0);
        write_limit(REG_Y_LIMIT, 15'd100);
        send_write(15'h7FFF, 15'h7FFF);
        send_read();
        wait_idle();
        write_limit(REG_X_LIMIT, 15'h7FFF);
        write_limit(REG_Y_LIMIT, 15'h7FFF);
        send_read();
    endtask

    // drive both accumulators into saturation, x up and y down, with no idling anywhere
    task automatic test_saturation();
        no_idle = 1'b1;
        repeat (260)
        begin
            send_byte(random_header());
            send_byte(8'h7F);
            send_byte(8'h80);
        end
        send_read();
        send_poll(3'b111);
        no_idle = 1'b0;
    endtask

    // answer side stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        answer_holdoff = 150;
        repeat (40)
        begin
            if ($urandom_range(1) == 0)
                send_poll(BTN_W'($urandom));
            else
                send_read();
        end
    endtask

    // random mix of well-formed packets, host requests and noise
    task automatic run_traffic(input int count);
        int start;
        int pick;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_packet();
            else if (pick < 70)
                send_poll(BTN_W'($urandom));
            else if (pick < 82)
                send_read();
            else if (pick < 90)
                send_write(POS_W'($urandom), POS_W'($urandom));
            else
                send_request(random_fill(op_e_t'($urandom_range(3))));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(40);
        // steady stretch, no idling on either side
        wait_idle();
        write_limit(REG_X_LIMIT, POS_W'($urandom));
        write_limit(REG_Y_LIMIT, POS_W'($urandom));
        no_idle = 1'b1;
        run_traffic(20);
        no_idle = 1'b0;
        // tight limits
        wait_idle();
        write_limit(REG_X_LIMIT, POS_W'($urandom_range(300)));
        write_limit(REG_Y_LIMIT, POS_W'($urandom_range(300)));
        run_traffic(20);
        // back to full range
        wait_idle();
        write_limit(REG_X_LIMIT, 15'h7FFF);
        write_limit(REG_Y_LIMIT, 15'h7FFF);
        run_traffic(20);
    endtask

    // main sequence
    initial
    begin
        pkt_phase = PH_HEADER;
        held_buttons = '0;
        sticky_hits = '0;
        motion_x_acc = '0;
        motion_y_acc = '0;
        cur_x = '0;
        cur_y = '0;
        limit_x = LIMIT_RESET;
        limit_y = LIMIT_RESET;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_answers();
        test_packet_decoding();
        test_limits();
        test_saturation();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
